// File: rtl/fire_command_frame_validator_unit_macros.svh
// ---------------------------------------------------------------------------
// fire command frame validator - assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ---------------------------------------------------------------------------
`ifndef FIRE_COMMAND_FRAME_VALIDATOR_UNIT_MACROS_SVH
`define FIRE_COMMAND_FRAME_VALIDATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FCFV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcfv assertion failed");

// next-cycle implication
`define FCFV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcfv assertion failed");

`endif

// File: rtl/fcfv_pkg.sv
// ---------------------------------------------------------------------------
// fcfv_pkg
// types, constants and the crc byte step for the fire command frame validator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcfv_pkg;

  typedef enum logic [2:0] {
    ST_FIRE         = 3'd0,
    ST_DISARMED     = 3'd1,
    ST_CRC_MISMATCH = 3'd2,
    ST_UNKNOWN_CMD  = 3'd3,
    ST_DUPLICATE_ID = 3'd4,
    ST_BAD_CHANNEL  = 3'd5,
    ST_TOO_SHORT    = 3'd6
  } status_e;

  localparam logic [4:0]  FrameBytes = 5'd24;
  localparam logic [4:0]  CrcBytes   = 5'd20;
  localparam logic [4:0]  CmdFirst   = 5'd1;
  localparam logic [4:0]  CmdLast    = 5'd5;
  localparam logic [4:0]  IdFirst    = 5'd12;
  localparam logic [4:0]  IdLast     = 5'd15;
  localparam logic [4:0]  ChanPos    = 5'd16;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;

  // "FIRE" and its terminating zero
  localparam logic [7:0] CmdText [5] = '{8'h46, 8'h49, 8'h52, 8'h45, 8'h00};

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

endpackage

// File: rtl/fire_command_frame_validator_unit.sv
// Fire command frame validator. Takes a 24-byte command frame one beat (one
// byte) per cycle with a last-beat mark, runs a reflected CRC-32 over bytes
// 0 to 19, collects command text, id (bytes 12-15, little-endian), channel
// (byte 16) and received CRC (bytes 20-23), and on the last beat gives one
// status beat with id and channel. Checks run in order: length, arm switch,
// CRC, command "FIRE" with a terminating zero, id unlike the last fired id,
// channel below CHANNEL_COUNT; the id is recorded before the channel check.
// A short frame reports too short with zero id and channel; bytes past the
// 24th are ignored. Rate: one byte every cycle, the byte-wide CRC step being
// combinational; the status beat appears in the result register in the
// cycle after the last byte is taken. The input stalls only while that
// register holds a status beat the consumer has not yet taken.
// ---------------------------------------------------------------------------
// fire_command_frame_validator_unit
// byte-serial command frame checker with registered status output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fire_command_frame_validator_unit #(
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_last_i,
  input  logic              arm_switch_i,
  // status output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fcfv_pkg::status_e status_o,
  output logic [7:0]        target_channel_o,
  output logic [31:0]       command_id_o
);
  import fcfv_pkg::*;

  // frame state
  logic [4:0]  byte_count_q, byte_count_d;
  logic [31:0] crc_q, crc_d;
  logic        cmd_match_q, cmd_match_d;
  logic [31:0] frame_id_q, frame_id_d;
  logic [7:0]  frame_chan_q, frame_chan_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic [31:0] last_id_q, last_id_d;

  // result register
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  logic [7:0]  chan_q, chan_d;
  logic [31:0] id_q, id_d;

  // state after folding in the current byte
  logic [4:0]  count_upd;
  logic [31:0] crc_upd;
  logic        cmd_upd;
  logic        active;
  logic [2:0]  cmd_idx;
  logic        in_acc;
  logic        produce;
  logic        fire_ok;

  // only a full, untaken result register holds back the byte stream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign produce    = in_acc & frame_last_i;

  assign active  = byte_count_q < FrameBytes;
  assign cmd_idx = byte_count_q[2:0] - 3'd1;

  always_comb begin
    count_upd  = byte_count_q;
    crc_upd    = crc_q;
    cmd_upd    = cmd_match_q;
    frame_id_d = frame_id_q;
    frame_chan_d = frame_chan_q;
    rx_crc_d   = rx_crc_q;
    if (in_acc && active) begin
      count_upd = byte_count_q + 5'd1;
      if (byte_count_q < CrcBytes) begin
        crc_upd = crc_byte(crc_q, rx_byte_i);
      end
      // command text sits in bytes 1 to 5
      if (byte_count_q >= CmdFirst && byte_count_q <= CmdLast &&
          rx_byte_i != CmdText[cmd_idx]) begin
        cmd_upd = 1'b0;
      end
      // little-endian fields shift in from the top
      if (byte_count_q >= IdFirst && byte_count_q <= IdLast) begin
        frame_id_d = {rx_byte_i, frame_id_q[31:8]};
      end
      if (byte_count_q == ChanPos) begin
        frame_chan_d = rx_byte_i;
      end
      if (byte_count_q >= CrcBytes) begin
        rx_crc_d = {rx_byte_i, rx_crc_q[31:8]};
      end
    end
  end

  // frame verdict, in priority order
  always_comb begin
    fire_ok  = 1'b0;
    status_d = status_q;
    chan_d   = chan_q;
    id_d     = id_q;
    if (produce) begin
      chan_d = frame_chan_d;
      id_d   = frame_id_d;
      if (count_upd < FrameBytes) begin
        status_d = ST_TOO_SHORT;
        chan_d   = 8'h00;
        id_d     = 32'h0;
      end else if (!arm_switch_i) begin
        status_d = ST_DISARMED;
      end else if (rx_crc_d != ~crc_upd) begin
        status_d = ST_CRC_MISMATCH;
      end else if (!cmd_upd) begin
        status_d = ST_UNKNOWN_CMD;
      end else if (frame_id_d == last_id_q) begin
        status_d = ST_DUPLICATE_ID;
      end else begin
        // id is taken as fired even if the channel is then refused
        fire_ok  = 1'b1;
        status_d = ({1'b0, frame_chan_d} < 9'(CHANNEL_COUNT)) ? ST_FIRE : ST_BAD_CHANNEL;
      end
    end
  end

  always_comb begin
    last_id_d = fire_ok ? frame_id_d : last_id_q;
    if (produce) begin
      // frame end: restart the per-frame state
      byte_count_d = 5'd0;
      crc_d        = CrcInit;
      cmd_match_d  = 1'b1;
    end else begin
      byte_count_d = count_upd;
      crc_d        = crc_upd;
      cmd_match_d  = cmd_upd;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 5'd0;
      crc_q        <= CrcInit;
      cmd_match_q  <= 1'b1;
      last_id_q    <= 32'h0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
      cmd_match_q  <= cmd_match_d;
      last_id_q    <= last_id_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload and unwritten-until-filled stores, no reset
  always_ff @(posedge clk_i) begin
    frame_id_q   <= frame_id_d;
    frame_chan_q <= frame_chan_d;
    rx_crc_q     <= rx_crc_d;
    status_q     <= status_d;
    chan_q       <= chan_d;
    id_q         <= id_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign target_channel_o = chan_q;
  assign command_id_o     = id_q;

endmodule

// File: rtl/fcfv_checker.sv
// ---------------------------------------------------------------------------
// fcfv_checker
// port-level checks for the fire command frame validator, bound to the top
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fire_command_frame_validator_unit_macros.svh"

module fcfv_checker #(
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fcfv_pkg::status_e status_o,
  input logic [7:0]        target_channel_o,
  input logic [31:0]       command_id_o
);
  import fcfv_pkg::*;

  logic        chan_in_range;
  logic        out_held;
  logic        fields_zero;
  logic [42:0] result_bits;

  assign chan_in_range = {1'b0, target_channel_o} < 9'(CHANNEL_COUNT);
  assign out_held      = out_valid_o && out_stall_i;
  assign fields_zero   = (target_channel_o == 8'h00) && (command_id_o == 32'h0);
  assign result_bits   = {status_o, target_channel_o, command_id_o};

  // input back-pressure only comes from a held status beat
  `FCFV_ASSERT_IMPL(a_stall_needs_result, in_stall_o, out_valid_o)

  `FCFV_ASSERT_NEXT(a_result_held, out_held, out_valid_o && $stable(result_bits))

  `FCFV_ASSERT_IMPL(a_short_clears_fields, out_valid_o && status_o == ST_TOO_SHORT, fields_zero)

  `FCFV_ASSERT_IMPL(a_fire_channel_valid, out_valid_o && status_o == ST_FIRE, chan_in_range)

  `FCFV_ASSERT_IMPL(a_bad_channel_real, out_valid_o && status_o == ST_BAD_CHANNEL, !chan_in_range)

endmodule

bind fire_command_frame_validator_unit fcfv_checker #(
  .CHANNEL_COUNT(CHANNEL_COUNT)
) u_fcfv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .target_channel_o (target_channel_o),
  .command_id_o     (command_id_o)
);

// File: tb/tb_fire_command_frame_validator_unit.sv
// ---------------------------------------------------------------------------
// tb_fire_command_frame_validator_unit
// self-checking bench: command frames in one beat per byte, status beats out
// ---------------------------------------------------------------------------
// A queue of byte beats is filled up front. It starts with frames that reach
// every status code and each corner of the checker. After those come random
// frames: mostly well formed with a correct crc, the rest with a bad crc, a
// bad command, cut short, or plain noise. A clocked driver offers the beats
// with random idle bursts. A clocked monitor takes the status beats with
// random stall bursts. Once during the run it holds off for a long stretch
// so that the block backs up onto its input. Every accepted byte goes
// through a local copy of the frame checker, and each status beat is
// compared field by field with the oldest outstanding verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fire_command_frame_validator_unit;
  import fcfv_pkg::*;

  localparam int unsigned CHANNEL_COUNT = 4;
  localparam int          FRAME_LEN     = 24;
  localparam int          CRC_SPAN      = 20;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam int          RANDOM_BEATS  = 760;
  localparam int          CALM_TAIL     = 120;     // beats left when idling stops
  localparam int          HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          CYCLE_LIMIT   = 200000;

  // command text plus its terminating zero
  localparam logic [7:0] FIRE_TEXT [5] = '{8'h46, 8'h49, 8'h52, 8'h45, 8'h00};

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       arm;
  } beat_t;

  typedef struct {
    status_e     status;
    logic [7:0]  channel;
    logic [31:0] id;
  } verdict_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i    = 8'h00;
  logic        frame_last_i = 1'b0;
  logic        arm_switch_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  status_e     status_o;
  logic [7:0]  target_channel_o;
  logic [31:0] command_id_o;

  beat_t    byte_q [$];      // beats waiting to be offered
  verdict_t verdict_q [$];   // status beats still owed by the block

  // checker state, as it stands after reset
  int          frame_fill = 0;
  logic [31:0] crc_run    = '1;
  logic        cmd_ok     = 1'b1;
  logic [31:0] id_seen    = '0;
  logic [7:0]  chan_seen  = '0;
  logic [31:0] crc_seen   = '0;
  logic [31:0] last_fired = '0;

  int   beats_taken   = 0;
  int   results_seen  = 0;
  int   mismatches    = 0;
  int   cycle_cnt     = 0;
  int   send_gap      = 0;
  int   take_gap      = 0;
  int   send_idle_pct = 10;
  int   take_idle_pct = 10;
  int   hold_left     = 0;
  bit   hold_done     = 1'b0;
  logic holding       = 1'b0;  // receiver is in its long hold-off
  logic calm          = 1'b0;  // end of the run: no more idling

  fire_command_frame_validator_unit #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_last_i    (frame_last_i),
    .arm_switch_i    (arm_switch_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .target_channel_o(target_channel_o),
    .command_id_o    (command_id_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    r = acc ^ {24'h0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // one accepted byte through the checker; a last byte queues a verdict
  function automatic void check_frame_byte(input logic [7:0] b, input logic is_last,
                                           input logic arm);
    verdict_t v;
    if (frame_fill < FRAME_LEN) begin
      if (frame_fill < CRC_SPAN) crc_run = crc32_step(crc_run, b);
      if (frame_fill >= 1 && frame_fill <= 5 && b != FIRE_TEXT[frame_fill - 1]) cmd_ok = 1'b0;
      if (frame_fill >= 12 && frame_fill <= 15) id_seen = {b, id_seen[31:8]};
      if (frame_fill == 16) chan_seen = b;
      if (frame_fill >= CRC_SPAN) crc_seen = {b, crc_seen[31:8]};
      frame_fill++;
    end
    if (is_last) begin
      if (frame_fill < FRAME_LEN) begin
        v = '{ST_TOO_SHORT, 8'h00, 32'h0};
      end else begin
        v.channel = chan_seen;
        v.id      = id_seen;
        if (!arm) v.status = ST_DISARMED;
        else if (crc_seen != ~crc_run) v.status = ST_CRC_MISMATCH;
        else if (!cmd_ok) v.status = ST_UNKNOWN_CMD;
        else if (id_seen == last_fired) v.status = ST_DUPLICATE_ID;
        else begin
          // id is taken even when the channel turns out bad
          last_fired = id_seen;
          v.status   = (chan_seen < CHANNEL_COUNT) ? ST_FIRE : ST_BAD_CHANNEL;
        end
      end
      verdict_q.push_back(v);
      frame_fill = 0;
      crc_run    = '1;
      cmd_ok     = 1'b1;
    end
  endfunction

  // a frame of len beats; cmd_flaw spoils one command byte before the crc,
  // crc_flaw flips one bit anywhere in the 24 bytes after it
  function automatic void queue_frame(input logic [31:0] id, input logic [7:0] chan,
                                      input int len, input logic arm,
                                      input int cmd_flaw, input bit crc_flaw);
    logic [7:0]  f [FRAME_LEN];
    logic [31:0] crc;
    beat_t       bt;
    int          pos;
    int          bit_sel;
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'($urandom());
    for (int i = 0; i < 5; i++) f[1 + i] = FIRE_TEXT[i];
    for (int i = 0; i < 4; i++) f[12 + i] = id[8*i +: 8];
    f[16] = chan;
    if (cmd_flaw != 0) f[cmd_flaw] ^= 8'($urandom_range(1, 255));
    crc = '1;
    for (int i = 0; i < CRC_SPAN; i++) crc = crc32_step(crc, f[i]);
    crc = ~crc;
    for (int i = 0; i < 4; i++) f[CRC_SPAN + i] = crc[8*i +: 8];
    if (crc_flaw) begin
      pos     = $urandom_range(0, FRAME_LEN - 1);
      bit_sel = $urandom_range(0, 7);
      f[pos][bit_sel] = ~f[pos][bit_sel];
    end
    for (int i = 0; i < len; i++) begin
      bt.data    = (i < FRAME_LEN) ? f[i] : 8'($urandom());
      bt.is_last = (i == len - 1);
      bt.arm     = (i == len - 1) ? arm : 1'($urandom());
      byte_q.push_back(bt);
    end
  endfunction

  // random bytes ending in a last mark
  function automatic void queue_noise(input int len);
    beat_t bt;
    for (int i = 0; i < len; i++) begin
      bt.data    = 8'($urandom());
      bt.is_last = (i == len - 1);
      bt.arm     = 1'($urandom());
      byte_q.push_back(bt);
    end
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 20;
    endcase
  endfunction

  // byte driver
  always @(posedge clk_i) begin : drive
    beat_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        check_frame_byte(rx_byte_i, frame_last_i, arm_switch_i);
        beats_taken++;
      end
      calm <= (byte_q.size() < CALM_TAIL);
      // a stalled beat stays put; otherwise choose what to offer next
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!holding && byte_q.size() >= CALM_TAIL &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap   = $urandom_range(1, 18) - 1;
          in_valid_i <= 1'b0;
        end else begin
          nxt = byte_q.pop_front();
          in_valid_i   <= 1'b1;
          rx_byte_i    <= nxt.data;
          frame_last_i <= nxt.is_last;
          arm_switch_i <= nxt.arm;
        end
      end
      if ($urandom_range(0, 63) == 0) send_idle_pct = pick_idle_pct();
    end
  end

  // status monitor and receiver stall
  always @(posedge clk_i) begin : watch
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected status beat: status %0d channel %0d id %h",
                     status_o, target_channel_o, command_id_o);
        end else begin
          want = verdict_q.pop_front();
          if (status_o !== want.status || target_channel_o !== want.channel ||
              command_id_o !== want.id) begin
            mismatches++;
            if (mismatches <= 10)
              $display("status beat mismatch: expected %0d/%0d/%h, got %0d/%0d/%h",
                       want.status, want.channel, want.id,
                       status_o, target_channel_o, command_id_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen >= 20) begin
        // long hold-off: the result register fills and the input backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (take_gap > 0) begin
        take_gap--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < take_idle_pct) begin
        take_gap = $urandom_range(1, 18) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      holding <= (hold_left > 0);
      if ($urandom_range(0, 63) == 0) take_idle_pct = pick_idle_pct();
    end
  end

  initial begin : stimulus
    int          beats_total;
    int          random_target;
    int          pick;
    logic [31:0] id;
    logic [7:0]  chan;
    int          len;
    logic        arm;

    queue_frame(32'h0, 8'd0, 1, 1'b1, 0, 1'b0);              // single byte, too short
    queue_frame(32'h0, 8'd0, 23, 1'b1, 0, 1'b0);             // one byte short
    queue_frame(32'h0, 8'd0, 24, 1'b1, 0, 1'b0);             // id zero equals reset last id
    queue_frame(32'h1, 8'd0, 24, 1'b0, 0, 1'b0);             // disarmed
    queue_frame(32'h1, 8'd0, 24, 1'b0, 0, 1'b1);             // disarmed ahead of bad crc
    queue_frame(32'h1, 8'd0, 24, 1'b1, 0, 1'b1);             // crc mismatch
    queue_frame(32'h1, 8'd0, 24, 1'b1, 1, 1'b0);             // wrong first letter
    queue_frame(32'h1, 8'd0, 24, 1'b1, 5, 1'b0);             // no terminating zero
    queue_frame(32'h1, 8'd3, 24, 1'b1, 0, 1'b0);             // fire on the top channel
    queue_frame(32'h1, 8'd3, 24, 1'b1, 0, 1'b0);             // same id again
    queue_frame(32'hFFFF_FFFF, 8'hFF, 24, 1'b1, 0, 1'b0);    // bad channel, id still taken
    queue_frame(32'hFFFF_FFFF, 8'h00, 24, 1'b1, 0, 1'b0);    // so this one is a duplicate
    queue_frame(32'h8000_0000, 8'd4, 24, 1'b1, 0, 1'b0);     // first channel past the count
    queue_frame(32'h0000_0002, 8'd1, 31, 1'b1, 0, 1'b0);     // overlong, tail ignored
    queue_frame(32'h1234_5678, 8'd0, 24, 1'b1, 2, 1'b1);     // crc checked before command

    // random frames, weighted towards well-formed ones that reach the id checks
    random_target = byte_q.size() + RANDOM_BEATS;
    while (byte_q.size() < random_target) begin
      pick = $urandom_range(0, 99);
      id   = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : $urandom();
      chan = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom());
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 32) : FRAME_LEN;
      arm  = ($urandom_range(0, 9) != 0);
      if (pick < 60) queue_frame(id, chan, len, arm, 0, 1'b0);
      else if (pick < 70) queue_frame(id, chan, len, arm, 0, 1'b1);
      else if (pick < 80) queue_frame(id, chan, len, arm, $urandom_range(1, 5), 1'b0);
      else if (pick < 90) queue_frame(id, chan, $urandom_range(1, FRAME_LEN - 1), arm, 0, 1'b0);
      else queue_noise($urandom_range(1, 40));
    end
    beats_total = byte_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken < beats_total) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fcfv_pkg.sv
rtl/fire_command_frame_validator_unit.sv
rtl/fcfv_checker.sv
tb/tb_fire_command_frame_validator_unit.sv
